// ===== hdl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg : shared types and constants for the block permutation cipher
// Widths, register indexes and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned MAX_BLOCK = 16;
  localparam int unsigned POS_W     = $clog2(MAX_BLOCK);
  localparam int unsigned CNT_W     = POS_W + 1;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned ENTRY_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_MAP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_CHAR    = 2'd3;

  localparam logic [CNT_W-1:0]  KEY_LENGTH_RESET = 5'd16;
  localparam logic [CHAR_W-1:0] PAD_CHAR_RESET   = 8'd35;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             store;     // write the accepted character, advance fill
    logic             drop;      // clear fill, invalid key
    logic             emit_load; // load one permuted character into the output
    logic             err_load;  // load the error result into the output
    logic             fill_clr;  // block finished, restart collection
    logic             fin;       // message end travels with the emitted block
    logic [POS_W-1:0] idx;       // output position being emitted
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic key_ok;    // key is a permutation of 0..n-1
    logic blk_full;  // this write completes the block
    logic idx_last;  // idx is the last position of the block
    logic out_free;  // output register can take a new result
  } sts_t;

  // Clamp the programmed length into 1..MAX_BLOCK
  function automatic logic [CNT_W-1:0] eff_len(input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] n;
    n = len;
    if (n == '0) begin
      n = CNT_W'(1);
    end else if (n > CNT_W'(MAX_BLOCK)) begin
      n = CNT_W'(MAX_BLOCK);
    end
    return n;
  endfunction

endpackage

// ===== hdl/bpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpc_ctrl : sequencer of the block permutation cipher
// Collects characters, then steps the output position over the block or
// issues the single error result.
// ----------------------------------------------------------------------------
module bpc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_end_i,
  output logic          in_ready_o,
  input  bpc_pkg::sts_t sts_i,
  output bpc_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_EMIT,
    ST_ERROR
  } state_e;

  state_e                    state_q, state_d;
  logic [bpc_pkg::POS_W-1:0] idx_q, idx_d;
  logic                      end_q, end_d;
  logic                      accept;

  assign in_ready_o = (state_q == ST_COLLECT);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    end_d   = end_q;
    cmd_o   = '0;
    cmd_o.idx = idx_q;
    cmd_o.fin = end_q;
    case (state_q)
      ST_COLLECT: begin
        if (accept) begin
          if (!sts_i.key_ok) begin
            cmd_o.drop = 1'b1;
            if (in_end_i) begin
              state_d = ST_ERROR;
            end
          end else begin
            cmd_o.store = 1'b1;
            if (sts_i.blk_full || in_end_i) begin
              state_d = ST_EMIT;
              idx_d   = '0;
              end_d   = in_end_i;
            end
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          idx_d = idx_q + 1'b1;
          if (sts_i.idx_last) begin
            cmd_o.fill_clr = 1'b1;
            state_d = ST_COLLECT;
          end
        end
      end
      ST_ERROR: begin
        if (sts_i.out_free) begin
          cmd_o.err_load = 1'b1;
          state_d = ST_COLLECT;
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      idx_q   <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      end_q   <= end_d;
    end
  end

endmodule

// ===== hdl/bpc_dp.sv =====
// ----------------------------------------------------------------------------
// bpc_dp : datapath of the block permutation cipher
// Configuration registers, block store, fill count, key check, permutation
// select and the output register.
// ----------------------------------------------------------------------------
module bpc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bpc_pkg::KEY_W-1:0]     cfg_data_i,
  input  logic [bpc_pkg::CHAR_W-1:0]    in_char_i,
  input  bpc_pkg::cmd_t                 cmd_i,
  output bpc_pkg::sts_t                 sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [bpc_pkg::CHAR_W-1:0]    out_char_o,
  output logic                          out_last_o,
  output logic                          out_fin_o,
  output logic                          out_err_o
);

  logic [bpc_pkg::CNT_W-1:0]  key_length_q;
  logic [bpc_pkg::KEY_W-1:0]  key_map_q;
  logic                       decode_q;
  logic [bpc_pkg::CHAR_W-1:0] pad_char_q;

  logic [bpc_pkg::CHAR_W-1:0] store_q [bpc_pkg::MAX_BLOCK];
  logic [bpc_pkg::CNT_W-1:0]  fill_q;

  logic                       out_valid_q;
  logic [bpc_pkg::CHAR_W-1:0] out_char_q;
  logic                       out_last_q, out_fin_q, out_err_q;

  logic [bpc_pkg::CNT_W-1:0]     n;
  logic [bpc_pkg::POS_W-1:0]     wr_pos;
  logic [bpc_pkg::CNT_W-1:0]     fill_next;
  logic [bpc_pkg::MAX_BLOCK-1:0] seen, want;
  logic                          range_ok;
  logic [bpc_pkg::POS_W-1:0]     key_k [bpc_pkg::MAX_BLOCK];
  logic [bpc_pkg::POS_W-1:0]     inv_pos, src_pos;
  logic [bpc_pkg::CHAR_W-1:0]    emit_char;

  assign n = bpc_pkg::eff_len(key_length_q);

  // Key entries and permutation check
  always_comb begin
    seen     = '0;
    range_ok = 1'b1;
    inv_pos  = '0;
    for (int k = 0; k < bpc_pkg::MAX_BLOCK; k++) begin
      key_k[k] = key_map_q[k*bpc_pkg::ENTRY_W +: bpc_pkg::POS_W];
      if (bpc_pkg::CNT_W'(k) < n) begin
        if ({1'b0, key_k[k]} >= n) begin
          range_ok = 1'b0;
        end
        seen[key_k[k]] = 1'b1;
        if (key_k[k] == cmd_i.idx) begin
          inv_pos = bpc_pkg::POS_W'(k);
        end
      end
    end
  end

  assign want = bpc_pkg::MAX_BLOCK'(({{bpc_pkg::MAX_BLOCK{1'b0}}, 1'b1} << n) - 1'b1);

  // A stale fill count restarts collection at position zero
  assign wr_pos    = (fill_q >= n) ? '0 : fill_q[bpc_pkg::POS_W-1:0];
  assign fill_next = {1'b0, wr_pos} + 1'b1;

  // Gather by key when encrypting, by inverse key when decrypting
  assign src_pos   = decode_q ? inv_pos : key_k[cmd_i.idx];
  assign emit_char = ({1'b0, src_pos} >= fill_q) ? pad_char_q : store_q[src_pos];

  assign sts_o.key_ok   = range_ok && (seen == want);
  assign sts_o.blk_full = (fill_next >= n);
  assign sts_o.idx_last = ({1'b0, cmd_i.idx} == (n - 1'b1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q <= bpc_pkg::KEY_LENGTH_RESET;
      key_map_q    <= '0;
      decode_q     <= 1'b0;
      pad_char_q   <= bpc_pkg::PAD_CHAR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bpc_pkg::CFG_KEY_LENGTH:  key_length_q <= cfg_data_i[bpc_pkg::CNT_W-1:0];
        bpc_pkg::CFG_KEY_MAP:     key_map_q    <= cfg_data_i;
        bpc_pkg::CFG_DECODE_MODE: decode_q     <= cfg_data_i[0];
        bpc_pkg::CFG_PAD_CHAR:    pad_char_q   <= cfg_data_i[bpc_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.drop || cmd_i.fill_clr) begin
      fill_q <= '0;
    end else if (cmd_i.store) begin
      fill_q <= fill_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      store_q[wr_pos] <= in_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load || cmd_i.err_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_char_q <= emit_char;
      out_last_q <= sts_o.idx_last;
      out_fin_q  <= sts_o.idx_last && cmd_i.fin;
      out_err_q  <= 1'b0;
    end else if (cmd_i.err_load) begin
      out_char_q <= '0;
      out_last_q <= 1'b1;
      out_fin_q  <= 1'b1;
      out_err_q  <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_fin_o   = out_fin_q;
  assign out_err_o   = out_err_q;

endmodule

// ===== hdl/block_permutation_cipher.sv =====
// ----------------------------------------------------------------------------
// block_permutation_cipher : block transposition cipher, one byte per request
// Collects message bytes into blocks of key_length and emits each block
// permuted by the programmed key, padding a final partial block.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tdata carries one message byte, tlast marks the last byte
//   of the message. A request is taken at a clock edge with tvalid and tready
//   high. While a block is being collected a byte is taken every cycle.
//   When a block completes (or the message ends) the block is emitted, one
//   byte per cycle while the output register is free, and no input is taken
//   meanwhile. The first byte of a block is loaded into the output register
//   from the emit state, once that register is free.
//   Output stream: tdata is the permuted byte, tlast marks the last byte of
//   the block, tuser[0] marks the last byte of the message, tuser[1] marks
//   the single error result sent at message end when the key is not a
//   permutation of 0..key_length-1 (data is then dropped).
//   A single output register parts the two sides: a stalled receiver holds
//   the emission at the current byte, and a new byte may be collected while
//   the final result of a block still waits.
//   Configuration: write the register index and data with cfg_valid_i; it is
//   always ready; the user must write it only while the block is idle, which is unchecked.
//   Reset: key_length 16, key_map zero, encode mode, pad '#', no partial
//   block held; the block store holds no meaningful data until written.
// ----------------------------------------------------------------------------
module block_permutation_cipher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bpc_pkg::KEY_W-1:0]     cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_char
  input  logic                          s_axis_tlast,  // message_end
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [7:0] out_char
  output logic                          m_axis_tlast,  // run_last
  output logic [1:0]                    m_axis_tuser   // [0] final_of_message, [1] key_error
);

  bpc_pkg::cmd_t cmd;
  bpc_pkg::sts_t sts;
  logic          out_fin, out_err;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  bpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_end_i   (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bpc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_char_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_fin_o   (out_fin),
    .out_err_o   (out_err)
  );

  assign m_axis_tuser = {out_err, out_fin};

  // An error result is a lone zero byte closing the message
  a_err_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |->
      (m_axis_tdata == '0 && m_axis_tlast && m_axis_tuser[0]))
    else $error("error result malformed");

  // Message end only on the last byte of a block
  a_fin_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("final_of_message without run_last");

  // Bytes are stored only on an accepted request, never during emission
  a_store_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.store |-> (s_axis_tvalid && s_axis_tready && !cmd.emit_load))
    else $error("store without accepted request");

  // A result is loaded only when the output register is free
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_load || cmd.err_load) |-> (!$past(1'b0) && sts.out_free))
    else $error("output overwritten");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench : self-checking bench for block_permutation_cipher
// Drives message bytes on the input stream and configuration writes on the
// register channel. A software model of the cipher predicts every output
// byte, and each result taken from the output stream is compared with the
// oldest prediction. Directed cases come first, then random messages.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 430;
  localparam int unsigned IDLE_GAP     = 4;
  localparam int unsigned END_GAP      = 40;

  localparam logic [bpc_pkg::KEY_W-1:0] KEY_IDENT = 64'hFEDC_BA98_7654_3210;
  localparam logic [bpc_pkg::KEY_W-1:0] KEY_REV16 = 64'h0123_4567_89AB_CDEF;

  typedef struct packed {
    logic [bpc_pkg::CHAR_W-1:0] out_char;
    logic                       run_last;
    logic                       final_of_msg;
    logic                       key_err;
  } cipher_res_t;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [bpc_pkg::KEY_W-1:0]     cfg_data_i    = '0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata  = '0;
  logic                          s_axis_tlast  = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [7:0]                    m_axis_tdata;
  logic                          m_axis_tlast;
  logic [1:0]                    m_axis_tuser;

  // shadow copy of the registers and of the block being collected
  logic [4:0]                 shadow_len    = bpc_pkg::KEY_LENGTH_RESET;
  logic [bpc_pkg::KEY_W-1:0]  shadow_key    = '0;
  logic                       shadow_decode = 1'b0;
  logic [bpc_pkg::CHAR_W-1:0] shadow_pad    = bpc_pkg::PAD_CHAR_RESET;
  logic [bpc_pkg::CHAR_W-1:0] block_copy [bpc_pkg::MAX_BLOCK];
  int                         fill_level    = 0;

  cipher_res_t expected_chars [$];
  int          fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          tx_quiet    = 1'b0;
  bit          rx_quiet    = 1'b0;

  block_permutation_cipher u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Cipher model
  // ---------------------------------------------------------------------------
  function automatic int block_len();
    int n;
    n = int'(shadow_len);
    if (n == 0) begin
      n = 1;
    end else if (n > bpc_pkg::MAX_BLOCK) begin
      n = bpc_pkg::MAX_BLOCK;
    end
    return n;
  endfunction

  function automatic bit key_is_perm(input int n);
    logic [15:0] seen;
    logic [3:0]  v;
    int          k;
    seen = '0;
    for (k = 0; k < n; k++) begin
      v = shadow_key[4*k +: 4];
      if (v >= n) return 1'b0;
      seen[v] = 1'b1;
    end
    return seen == 16'((32'd1 << n) - 1);
  endfunction

  function automatic void push_result(input logic [7:0] ch, input logic last,
                                      input logic fin, input logic err);
    cipher_res_t r;
    r.out_char     = ch;
    r.run_last     = last;
    r.final_of_msg = fin;
    r.key_err      = err;
    expected_chars.push_back(r);
  endfunction

  // Work out the results caused by one accepted byte
  function automatic void cipher_predict(input logic [7:0] ch, input logic msg_end);
    int         n;
    int         k;
    logic [7:0] perm [16];
    n = block_len();
    if (!key_is_perm(n)) begin
      // bad key: drop the byte, report once at message end
      fill_level = 0;
      if (msg_end) push_result(8'h00, 1'b1, 1'b1, 1'b1);
      return;
    end
    // a fill left over from a longer block length restarts collection
    if (fill_level >= n) fill_level = 0;
    block_copy[fill_level] = ch;
    fill_level++;
    if (fill_level < n && !msg_end) return;
    for (k = fill_level; k < n; k++) block_copy[k] = shadow_pad;
    for (k = 0; k < n; k++) begin
      if (shadow_decode) begin
        perm[shadow_key[4*k +: 4]] = block_copy[k];
      end else begin
        perm[k] = block_copy[shadow_key[4*k +: 4]];
      end
    end
    for (k = 0; k < n; k++) begin
      push_result(perm[k], k == n - 1, (k == n - 1) && msg_end, 1'b0);
    end
    fill_level = 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure at the falling edge, check at the rising
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    m_axis_tready <= rx_quiet || ($urandom_range(99, 0) >= 29);
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    cipher_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected result: out_char %0h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        check_field("out_char", want.out_char, m_axis_tdata);
        check_field("run_last", 8'(want.run_last), 8'(m_axis_tlast));
        check_field("final_of_message", 8'(want.final_of_msg), 8'(m_axis_tuser[0]));
        check_field("key_error", 8'(want.key_err), 8'(m_axis_tuser[1]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request drivers, all entered and left at a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] ch, input logic msg_end);
    while (!tx_quiet && $urandom_range(99, 0) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= msg_end;
    do @(posedge clk_i); while (!s_axis_tready);
    cipher_predict(ch, msg_end);
    @(negedge clk_i);
  endtask

  // Hold the input until every predicted result has left, then let the
  // pipeline settle so a register write cannot land on work in flight
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(negedge clk_i);
    repeat (IDLE_GAP) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bpc_pkg::KEY_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      bpc_pkg::CFG_KEY_LENGTH:  shadow_len    = value[4:0];
      bpc_pkg::CFG_KEY_MAP:     shadow_key    = value;
      bpc_pkg::CFG_DECODE_MODE: shadow_decode = value[0];
      bpc_pkg::CFG_PAD_CHAR:    shadow_pad    = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [bpc_pkg::KEY_W-1:0] len,
                              input logic [bpc_pkg::KEY_W-1:0] key,
                              input logic [bpc_pkg::KEY_W-1:0] mode,
                              input logic [bpc_pkg::KEY_W-1:0] pad);
    cfg_write(bpc_pkg::CFG_KEY_LENGTH, len);
    cfg_write(bpc_pkg::CFG_KEY_MAP, key);
    cfg_write(bpc_pkg::CFG_DECODE_MODE, mode);
    cfg_write(bpc_pkg::CFG_PAD_CHAR, pad);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_state();
    // all-zero key map is no permutation: the message gives one error result
    send_char(8'h41, 1'b0);
    send_char(8'h42, 1'b1);
    wait_idle();
    // reversed key, padding with the reset pad character
    cfg_write(bpc_pkg::CFG_KEY_MAP, KEY_REV16);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h5A, 1'b1);
    wait_idle();
  endtask

  task automatic test_length_extremes();
    program_regs(64'd1, KEY_IDENT, 64'd0, 64'hFF);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    wait_idle();
    // zero length behaves as one
    program_regs(64'd0, KEY_IDENT, 64'd1, 64'h00);
    send_char(8'h80, 1'b1);
    wait_idle();
    // 31 clamps to the maximum; upper data bits must be ignored
    program_regs('1, KEY_IDENT, '1, '1);
    send_char(8'h01, 1'b0);
    send_char(8'h7F, 1'b1);
    wait_idle();
  endtask

  task automatic test_decode_block();
    program_regs(64'd4, 64'hABCD_EF01_2345_1302, 64'd1, 64'h23);
    send_char(8'h10, 1'b0);
    send_char(8'h20, 1'b0);
    send_char(8'h30, 1'b0);
    send_char(8'h40, 1'b0);
    send_char(8'h50, 1'b1);
    wait_idle();
  endtask

  task automatic test_invalid_key();
    // duplicate entry
    program_regs(64'd4, 64'h0000_0000_0000_0012, 64'd0, 64'h23);
    send_char(8'h11, 1'b0);
    send_char(8'h22, 1'b0);
    send_char(8'h33, 1'b1);
    wait_idle();
    // entry beyond the block length
    cfg_write(bpc_pkg::CFG_KEY_MAP, 64'h0000_0000_0000_5210);
    send_char(8'h44, 1'b1);
    wait_idle();
  endtask

  task automatic test_stale_fill();
    program_regs(64'd8, KEY_IDENT, 64'd0, 64'h2E);
    send_char(8'hA1, 1'b0);
    send_char(8'hB2, 1'b0);
    send_char(8'hC3, 1'b0);
    wait_idle();
    // shorten the block below the fill held: the partial block is dropped
    program_regs(64'd2, KEY_IDENT, 64'd1, 64'h2E);
    send_char(8'h99, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_messages();
    int                        sent;
    int                        phase;
    int                        pick;
    int                        n;
    int                        len;
    int                        j;
    int                        k;
    logic [bpc_pkg::KEY_W-1:0] key;
    logic [4:0]                len_reg;
    logic [3:0]                swap;
    bit                        msg_end;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      // a stretch of phases with neither side idling
      tx_quiet = (phase >= 15 && phase < 25);
      rx_quiet = tx_quiet;
      pick = $urandom_range(9, 0);
      if (pick == 0) begin
        len_reg = 5'd1;
      end else if (pick == 1) begin
        len_reg = 5'd16;
      end else if (pick == 2) begin
        len_reg = ($urandom_range(1, 0) == 1) ? 5'd0 : 5'($urandom_range(31, 17));
      end else begin
        len_reg = 5'($urandom_range(16, 1));
      end
      cfg_write(bpc_pkg::CFG_KEY_LENGTH, {$urandom, 27'($urandom), len_reg});
      n = block_len();
      // shuffle 0..n-1 into the live entries, leave the rest random
      key = {$urandom, $urandom};
      for (k = 0; k < n; k++) key[4*k +: 4] = 4'(k);
      for (k = n - 1; k > 0; k--) begin
        j = $urandom_range(k, 0);
        swap = key[4*k +: 4];
        key[4*k +: 4] = key[4*j +: 4];
        key[4*j +: 4] = swap;
      end
      if ($urandom_range(99, 0) < 15) begin
        j = $urandom_range(n - 1, 0);
        if (n < bpc_pkg::MAX_BLOCK && (n == 1 || $urandom_range(1, 0) == 1)) begin
          key[4*j +: 4] = 4'($urandom_range(15, n));
        end else begin
          k = (j + $urandom_range(n - 1, 1)) % n;
          key[4*j +: 4] = key[4*k +: 4];
        end
      end
      cfg_write(bpc_pkg::CFG_KEY_MAP, key);
      cfg_write(bpc_pkg::CFG_DECODE_MODE, {$urandom, $urandom});
      cfg_write(bpc_pkg::CFG_PAD_CHAR, {$urandom, $urandom});
      // some messages run on into the next setting
      len = $urandom_range(2 * n + 1, 1);
      for (k = 1; k <= len; k++) begin
        msg_end = (k == len) && ($urandom_range(99, 0) >= 15);
        send_char(8'($urandom_range(255, 0)), msg_end);
        sent++;
      end
      phase++;
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_length_extremes();
    test_decode_block();
    test_invalid_key();
    test_stale_fill();
    test_random_messages();
    wait_idle();
    repeat (END_GAP) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bpc_pkg.sv
hdl/bpc_ctrl.sv
hdl/bpc_dp.sv
hdl/block_permutation_cipher.sv
bench/testbench.sv
